/* hdl/atlc_pkg.sv */
// ----------------------------------------------------------------------------
// atlc_pkg
// Shared widths, constants, codes and types of the tick latency compensator.
// ----------------------------------------------------------------------------
package atlc_pkg;

  // Field widths
  localparam int USEC_W  = 20;
  localparam int BIAS_W  = 20;
  localparam int DIG_W   = 4;
  localparam int SPAN_W  = 32;
  localparam int FIRE_W  = 14;
  localparam int LAT_W   = 17;
  localparam int BKT_W   = 3;
  localparam int BUCKETS = 8;

  // Timing constants in microseconds, and the averaging shift
  localparam int unsigned TICK_PERIOD_US_DEF  = 10000;
  localparam int unsigned US_PER_SECOND       = 1000000;
  localparam int unsigned GUARD_US            = 500;
  localparam int unsigned MIN_FRACTION_SAMPLE = 100;
  localparam int unsigned MAX_SAMPLE          = 80000;
  localparam int unsigned EMA_SHIFT           = 3;

  localparam logic [BKT_W-1:0] TOP_BUCKET = 3'd7;

  // Command codes
  localparam logic CMD_ARM  = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // One accepted input word
  typedef struct packed {
    logic                     command;
    logic [USEC_W-1:0]        now_usec;
    logic [DIG_W-1:0]         next_digits;
    logic signed [SPAN_W-1:0] measured_span;
    logic [DIG_W-1:0]         measured_digits;
    logic                     had_pixels;
  } item_t;

  // Read request to the average store: two registered read ports
  typedef struct packed {
    logic             en;
    logic [BKT_W-1:0] addr_a;
    logic [BKT_W-1:0] addr_b;
  } lat_rd_req_t;

  // Write request to the average store
  typedef struct packed {
    logic             en;
    logic [BKT_W-1:0] addr;
    logic [LAT_W-1:0] data;
  } lat_wr_req_t;

endpackage

/* hdl/atlc_ifs.sv */
// ----------------------------------------------------------------------------
// atlc_ifs
// Valid/ready channel interfaces: input words, result words, configuration.
// ----------------------------------------------------------------------------
interface atlc_in_if;
  import atlc_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     command;
  logic [USEC_W-1:0]        now_usec;
  logic [DIG_W-1:0]         next_digits;
  logic signed [SPAN_W-1:0] measured_span;
  logic [DIG_W-1:0]         measured_digits;
  logic                     had_pixels;

  modport source (
    output valid, command, now_usec, next_digits, measured_span,
           measured_digits, had_pixels,
    input  ready
  );
  modport sink (
    input  valid, command, now_usec, next_digits, measured_span,
           measured_digits, had_pixels,
    output ready
  );
endinterface

interface atlc_out_if;
  import atlc_pkg::*;

  logic              valid;
  logic              ready;
  logic [FIRE_W-1:0] fire_delay_us;
  logic [LAT_W-1:0]  comp_latency_us;
  logic              sample_taken;

  modport source (
    output valid, fire_delay_us, comp_latency_us, sample_taken,
    input  ready
  );
  modport sink (
    input  valid, fire_delay_us, comp_latency_us, sample_taken,
    output ready
  );
endinterface

interface atlc_cfg_if;
  import atlc_pkg::*;

  logic              valid;
  logic              ready;
  logic [BIAS_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

/* hdl/atlc_lat_mem.sv */
// ----------------------------------------------------------------------------
// atlc_lat_mem
// Eight-entry latency average store with two registered read ports, one
// write port, per-entry valid bits that stand in for the seed values, and a
// write-to-read bypass for a write landing on the same edge as a read.
// ----------------------------------------------------------------------------
module atlc_lat_mem (
  input  logic                           clk,
  input  logic                           rst_n,
  input  atlc_pkg::lat_rd_req_t          rd_req,
  input  atlc_pkg::lat_wr_req_t          wr_req,
  output logic [atlc_pkg::LAT_W-1:0]     rd_a_r,
  output logic [atlc_pkg::LAT_W-1:0]     rd_b_r
);
  import atlc_pkg::*;

  logic [LAT_W-1:0]   avg_mem [BUCKETS];
  logic [BUCKETS-1:0] vld_r;
  logic [BUCKETS-1:0] vld_nxt;

  // Seed average of each bucket after reset
  function automatic logic [LAT_W-1:0] avg_seed(input logic [BKT_W-1:0] b);
    logic [LAT_W-1:0] s;
    case (b)
      3'd0:    s = 17'd900;
      3'd1:    s = 17'd1800;
      3'd2:    s = 17'd3200;
      3'd3:    s = 17'd4600;
      3'd4:    s = 17'd6000;
      3'd5:    s = 17'd7400;
      3'd6:    s = 17'd8800;
      default: s = 17'd12800;
    endcase
    return s;
  endfunction

  // Store the written average
  always_ff @(posedge clk) begin
    if (wr_req.en) begin
      avg_mem[wr_req.addr] <= wr_req.data;
    end
  end

  // Mark an entry as written
  always_comb begin
    vld_nxt = vld_r;
    if (wr_req.en) begin
      vld_nxt[wr_req.addr] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // Registered reads; unwritten entries give the seed, a same-edge write wins
  always_ff @(posedge clk) begin
    if (rd_req.en) begin
      if (wr_req.en && (wr_req.addr == rd_req.addr_a)) begin
        rd_a_r <= wr_req.data;
      end else if (vld_r[rd_req.addr_a]) begin
        rd_a_r <= avg_mem[rd_req.addr_a];
      end else begin
        rd_a_r <= avg_seed(rd_req.addr_a);
      end
      if (wr_req.en && (wr_req.addr == rd_req.addr_b)) begin
        rd_b_r <= wr_req.data;
      end else if (vld_r[rd_req.addr_b]) begin
        rd_b_r <= avg_mem[rd_req.addr_b];
      end else begin
        rd_b_r <= avg_seed(rd_req.addr_b);
      end
    end
  end

endmodule

/* hdl/adaptive_tick_latency_compensator.sv */
// ----------------------------------------------------------------------------
// adaptive_tick_latency_compensator
// Learns per-bucket draw latency and schedules the next display tick early.
// ----------------------------------------------------------------------------
//  Channel  | Dir | Handshake         | Word
//  ---------+-----+-------------------+------------------------------------------
//  in_ch    | in  | valid/ready       | command, now_usec, digits, span, pixels
//  out_ch   | out | valid/ready       | fire_delay_us, comp_latency_us, taken
//  cfg_ch   | in  | valid/ready       | scan_bias_us (always ready)
//
//  One word per cycle sustained while the output is taken; a result is offered
//  once its input has passed the input register and reciprocal multiply for the
//  tick phase, the remainder and average-store read, and the fold and arm into
//  the output register. The average store keeps valid bits, so it is usable
//  right after reset. rst_n is synchronous, active low. A stalled output backs
//  up stage by stage; the input keeps taking words while any stage has room.
// ----------------------------------------------------------------------------
module adaptive_tick_latency_compensator #(
  parameter int unsigned TICK_PERIOD_US = atlc_pkg::TICK_PERIOD_US_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  atlc_in_if.sink    in_ch,
  atlc_out_if.source out_ch,
  atlc_cfg_if.sink   cfg_ch
);
  import atlc_pkg::*;

  // Phase arithmetic derived from the tick period
  localparam int PER_W   = $clog2(TICK_PERIOD_US + 1);
  localparam int LOG_P   = $clog2(TICK_PERIOD_US);
  localparam int SHIFT   = USEC_W + LOG_P;
  localparam int RECIP_W = USEC_W + 1;
  localparam int PROD_W  = USEC_W + RECIP_W;
  localparam int Q_W     = USEC_W - LOG_P + 1;
  localparam int QP_W    = Q_W + PER_W;
  localparam int CROSS_W = USEC_W + 2;
  localparam logic [63:0] RECIP_FULL =
    ((64'd1 << SHIFT) + 64'(TICK_PERIOD_US) - 64'd1) / 64'(TICK_PERIOD_US);
  localparam logic [RECIP_W-1:0] RECIP  = RECIP_W'(RECIP_FULL);
  localparam logic [PER_W-1:0]   PERIOD = PER_W'(TICK_PERIOD_US);

  // Clamp a digit count to the top bucket
  function automatic logic [BKT_W-1:0] clamp_digits(input logic [DIG_W-1:0] d);
    logic [BKT_W-1:0] r;
    if (d > DIG_W'(TOP_BUCKET)) begin
      r = TOP_BUCKET;
    end else begin
      r = BKT_W'(d);
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stage control
  // --------------------------------------------------------------------------
  logic s1_v_r, s2_v_r, s3_v_r, out_v_r;
  logic s1_v_nxt, s2_v_nxt, s3_v_nxt, out_v_nxt;
  logic s1_adv, s2_adv, s3_adv, in_acc, in_ready;

  assign s3_adv   = s3_v_r && (!out_v_r || out_ch.ready);
  assign s2_adv   = s2_v_r && (!s3_v_r || s3_adv);
  assign s1_adv   = s1_v_r && (!s2_v_r || s2_adv);
  assign in_ready = !s1_v_r || s1_adv;
  assign in_acc   = in_ch.valid && in_ready;

  always_comb begin
    s1_v_nxt  = in_acc ? 1'b1 : (s1_adv ? 1'b0 : s1_v_r);
    s2_v_nxt  = s1_adv ? 1'b1 : (s2_adv ? 1'b0 : s2_v_r);
    s3_v_nxt  = s2_adv ? 1'b1 : (s3_adv ? 1'b0 : s3_v_r);
    out_v_nxt = s3_adv ? 1'b1 : (out_ch.ready ? 1'b0 : out_v_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      s2_v_r  <= s2_v_nxt;
      s3_v_r  <= s3_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Configuration: scan bias
  // --------------------------------------------------------------------------
  logic [BIAS_W-1:0] bias_r;
  logic [BIAS_W-1:0] bias_nxt;

  assign cfg_ch.ready = 1'b1;
  assign bias_nxt     = cfg_ch.valid ? cfg_ch.data : bias_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bias_r <= '0;
    end else begin
      bias_r <= bias_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: capture the word, estimate the tick quotient
  // --------------------------------------------------------------------------
  item_t             s1_item_r;
  logic [PROD_W-1:0] s1_prod;
  logic [Q_W-1:0]    s1_q;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_item_r.command         <= in_ch.command;
      s1_item_r.now_usec        <= in_ch.now_usec;
      s1_item_r.next_digits     <= in_ch.next_digits;
      s1_item_r.measured_span   <= in_ch.measured_span;
      s1_item_r.measured_digits <= in_ch.measured_digits;
      s1_item_r.had_pixels      <= in_ch.had_pixels;
    end
  end

  assign s1_prod = PROD_W'(s1_item_r.now_usec) * PROD_W'(RECIP);
  assign s1_q    = s1_prod[SHIFT +: Q_W];

  // --------------------------------------------------------------------------
  // Stage 2: phase remainder, crossing test, bucket pick, store read
  // --------------------------------------------------------------------------
  item_t             s2_item_r;
  logic [Q_W-1:0]    s2_q_r;
  logic [QP_W-1:0]   s2_qp;
  logic [USEC_W:0]   s2_rem_raw;
  logic [USEC_W:0]   s2_rem_fix;
  logic [PER_W-1:0]  s2_rem;
  logic [PER_W-1:0]  s2_to_tick;
  logic [CROSS_W-1:0] s2_cross_sum;
  logic              s2_crosses;
  logic [BKT_W-1:0]  s2_bucket;
  logic [BKT_W-1:0]  s2_mdig;
  lat_rd_req_t       rd_req;

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s2_item_r <= s1_item_r;
      s2_q_r    <= s1_q;
    end
  end

  // Remainder with one correction step
  assign s2_qp      = QP_W'(s2_q_r) * QP_W'(PERIOD);
  assign s2_rem_raw = {1'b0, s2_item_r.now_usec} - (USEC_W + 1)'(s2_qp);
  assign s2_rem_fix = (s2_rem_raw >= (USEC_W + 1)'(PERIOD)) ?
                      s2_rem_raw - (USEC_W + 1)'(PERIOD) : s2_rem_raw;
  assign s2_rem     = PER_W'(s2_rem_fix);
  assign s2_to_tick = PERIOD - s2_rem;

  // Next tick lands in a new second: use the predicted digit bucket
  assign s2_cross_sum = CROSS_W'(s2_item_r.now_usec) + CROSS_W'(s2_to_tick)
                      + CROSS_W'(bias_r);
  assign s2_crosses   = s2_cross_sum >= CROSS_W'(US_PER_SECOND);
  assign s2_bucket    = s2_crosses ? clamp_digits(s2_item_r.next_digits)
                                   : '0;
  assign s2_mdig      = clamp_digits(s2_item_r.measured_digits);

  assign rd_req.en     = s2_adv;
  assign rd_req.addr_a = s2_mdig;
  assign rd_req.addr_b = s2_bucket;

  // --------------------------------------------------------------------------
  // Stage 3: fold the sample, arm with the (possibly fresh) average
  // --------------------------------------------------------------------------
  logic                     s3_cmd_r;
  logic signed [SPAN_W-1:0] s3_span_r;
  logic [BKT_W-1:0]         s3_mdig_r;
  logic                     s3_pix_r;
  logic [BKT_W-1:0]         s3_bucket_r;
  logic [PER_W-1:0]         s3_to_tick_r;
  logic [LAT_W-1:0]         rd_a_r, rd_b_r;
  logic                     skip_r, skip_nxt;

  logic [SPAN_W-2:0]        s3_measured;
  logic [SPAN_W-2:0]        s3_min_ok;
  logic                     s3_take;
  logic [LAT_W:0]           s3_avg_sum;
  logic [LAT_W-1:0]         s3_avg_new;
  logic [LAT_W-1:0]         s3_lat_sel;
  logic [LAT_W-1:0]         s3_lat_app;
  logic [LAT_W-1:0]         s3_to_tick_w;
  logic [LAT_W-1:0]         s3_delay_raw;
  logic [LAT_W-1:0]         s3_delay;
  lat_wr_req_t              wr_req;

  always_ff @(posedge clk) begin
    if (s2_adv) begin
      s3_cmd_r     <= s2_item_r.command;
      s3_span_r    <= s2_item_r.measured_span;
      s3_mdig_r    <= s2_mdig;
      s3_pix_r     <= s2_item_r.had_pixels;
      s3_bucket_r  <= s2_bucket;
      s3_to_tick_r <= s2_to_tick;
    end
  end

  atlc_lat_mem u_lat_mem (
    .clk    (clk),
    .rst_n  (rst_n),
    .rd_req (rd_req),
    .wr_req (wr_req),
    .rd_a_r (rd_a_r),
    .rd_b_r (rd_b_r)
  );

  // Guard bounds on the sample
  assign s3_measured = s3_span_r[SPAN_W-1] ? '0 : s3_span_r[SPAN_W-2:0];
  assign s3_min_ok   = (s3_mdig_r == '0) ? (SPAN_W - 1)'(MIN_FRACTION_SAMPLE)
                                         : (SPAN_W - 1)'(GUARD_US);
  assign s3_take     = (s3_cmd_r == CMD_TICK) && !skip_r && s3_pix_r
                    && (s3_measured >= s3_min_ok)
                    && (s3_measured < (SPAN_W - 1)'(MAX_SAMPLE));

  // Average with weight 1/8
  assign s3_avg_sum = (LAT_W + 1)'(rd_a_r) - (LAT_W + 1)'(rd_a_r >> EMA_SHIFT)
                    + (LAT_W + 1)'(s3_measured >> EMA_SHIFT);
  assign s3_avg_new = s3_avg_sum[LAT_W-1:0];

  // Forward a fresh fold into the arm bucket
  assign s3_lat_sel = (s3_take && (s3_mdig_r == s3_bucket_r)) ? s3_avg_new
                                                              : rd_b_r;

  // Leave the guard time before the tick
  assign s3_to_tick_w = LAT_W'(s3_to_tick_r);
  always_comb begin
    s3_lat_app = s3_lat_sel;
    if ((LAT_W + 1)'(s3_lat_sel) + (LAT_W + 1)'(GUARD_US) >
        (LAT_W + 1)'(s3_to_tick_r)) begin
      s3_lat_app = (s3_to_tick_r > PER_W'(GUARD_US)) ?
                   LAT_W'(s3_to_tick_r - PER_W'(GUARD_US)) : '0;
    end
  end

  // Raise a too-soon fire to the guard time
  assign s3_delay_raw = (s3_to_tick_w > s3_lat_app) ? s3_to_tick_w - s3_lat_app
                                                    : '0;
  assign s3_delay     = (s3_delay_raw < LAT_W'(GUARD_US)) ? LAT_W'(GUARD_US)
                                                          : s3_delay_raw;

  assign wr_req.en   = s3_adv && s3_take;
  assign wr_req.addr = s3_mdig_r;
  assign wr_req.data = s3_avg_new;

  // Arm sets the skip flag, every tick clears it
  assign skip_nxt = s3_adv ? (s3_cmd_r == CMD_ARM) : skip_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skip_r <= 1'b1;
    end else begin
      skip_r <= skip_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  logic [FIRE_W-1:0] out_fire_r;
  logic [LAT_W-1:0]  out_lat_r;
  logic              out_taken_r;

  always_ff @(posedge clk) begin
    if (s3_adv) begin
      out_fire_r  <= FIRE_W'(s3_delay);
      out_lat_r   <= s3_lat_app;
      out_taken_r <= s3_take;
    end
  end

  assign in_ch.ready            = in_ready;
  assign out_ch.valid           = out_v_r;
  assign out_ch.fire_delay_us   = out_fire_r;
  assign out_ch.comp_latency_us = out_lat_r;
  assign out_ch.sample_taken    = out_taken_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // Reciprocal quotient plus correction yields a true remainder
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    s2_v_r |-> (s2_rem_fix < (USEC_W + 1)'(PERIOD)))
    else $error("tick phase remainder out of range");

  // Applied latency is zero or leaves the guard time before the tick
  a_lat_guard: assert property (@(posedge clk) disable iff (!rst_n)
    s3_v_r |-> ((s3_lat_app == '0) ||
                ((LAT_W + 1)'(s3_lat_app) + (LAT_W + 1)'(GUARD_US) <=
                 (LAT_W + 1)'(s3_to_tick_r))))
    else $error("applied latency eats into the guard time");

  // A word leaving the last stage is offered on the output next cycle
  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    s3_adv |=> out_v_r)
    else $error("result lost between last stage and output register");

  // The store is written only by an advancing tick word
  a_wr_tick: assert property (@(posedge clk) disable iff (!rst_n)
    wr_req.en |-> (s3_v_r && (s3_cmd_r == CMD_TICK) && !skip_r))
    else $error("average written outside an accepted tick sample");

endmodule
